// ===== hw/rtl/ple_pkg.sv =====
package ple_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = 5;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int DATA_W   = 32;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	localparam logic [2:0] CMD_INS_FRONT = 3'd0;
	localparam logic [2:0] CMD_INS_REAR  = 3'd1;
	localparam logic [2:0] CMD_INS_POS   = 3'd2;
	localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [2:0] CMD_DEL_REAR  = 3'd4;
	localparam logic [2:0] CMD_DEL_POS   = 3'd5;
	localparam logic [2:0] CMD_DEL_VAL   = 3'd6;
	localparam logic [2:0] CMD_SEARCH    = 3'd7;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_BADPOS   = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic                     we;
		logic [IDX_W-1:0]         waddr;
		logic signed [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]         raddr;
	} mem_req_t;

endpackage

// ===== hw/rtl/positional_list_engine.sv =====
// Positional list engine: a bounded front-to-rear list of signed 32-bit words.
// Input channel (in_valid/in_stall) takes one command item: command, item and
// position. Output channel (out_valid/out_stall) returns one result item per
// command: status, removed_value, found_position and entry_count.
// The list lives in a single-port-write, registered-read store; a small
// sequencer moves entries one at a time through that port, and one 32-bit
// comparator scans for values.
// Steps per command (n entries, target index i):
//   rejected command (empty, full, bad position): straight to the result
//   insert: move entries i..n-1 up one place, then write the item at i
//   delete at a position: read and capture entry i, then move the
//   entries after it down one place; search: compare entries in order
//   from the front; delete by value adds that shift after the match
// One command at a time: in_stall is high from accept until the result is
// loaded, and the next command can be taken at the following edge.
// A finished result sits in the output register; the next command is
// accepted while it waits, but that command cannot finish until the
// receiver drops out_stall and takes the earlier result.
// Reset empties the list at once (count to zero); stored words are not
// cleared, as only live positions are ever read.
module positional_list_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        command,
	input  logic signed [ple_pkg::DATA_W-1:0] item,
	input  logic [4:0]                        position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic signed [ple_pkg::DATA_W-1:0] removed_value,
	output logic [4:0]                        found_position,
	output logic [4:0]                        entry_count
);

	localparam int IW = ple_pkg::IDX_W;
	localparam int CW = ple_pkg::CNT_W;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_UP_RD    = 10'b0000000010,
		S_UP_WR    = 10'b0000000100,
		S_TAKE_RD  = 10'b0000001000,
		S_TAKE_CAP = 10'b0000010000,
		S_DN_RD    = 10'b0000100000,
		S_DN_WR    = 10'b0001000000,
		S_SRCH_RD  = 10'b0010000000,
		S_SRCH_CMP = 10'b0100000000,
		S_OUT      = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	logic [CW-1:0]                     count_q, count_d;
	logic [IW-1:0]                     k_q, k_d;
	logic [IW-1:0]                     idx_q, idx_d;
	logic [2:0]                        cmd_q, cmd_d;
	logic signed [ple_pkg::DATA_W-1:0] item_q, item_d;
	logic [2:0]                        st_q, st_d;
	logic signed [ple_pkg::DATA_W-1:0] rem_q, rem_d;
	logic [CW-1:0]                     found_q, found_d;

	logic                              out_valid_q;
	logic [2:0]                        out_st_q;
	logic signed [ple_pkg::DATA_W-1:0] out_rem_q;
	logic [CW-1:0]                     out_found_q;
	logic [CW-1:0]                     out_cnt_q;

	ple_pkg::mem_req_t                 req;
	logic signed [ple_pkg::DATA_W-1:0] rdata;

	logic          in_acc;
	logic          out_load;
	logic [CW-1:0] k_ext;
	logic [CW-1:0] pos_m1;

	ple_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign k_ext    = CW'(k_q);
	assign pos_m1   = position - CW'(1);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		k_d       = k_q;
		idx_d     = idx_q;
		cmd_d     = cmd_q;
		item_d    = item_q;
		st_d      = st_q;
		rem_d     = rem_q;
		found_d   = found_q;
		req.we    = 1'b0;
		req.waddr = k_q;
		req.wdata = rdata;
		req.raddr = k_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cmd_d   = command;
					item_d  = item;
					st_d    = ple_pkg::ST_OK;
					rem_d   = '0;
					found_d = '0;
					unique case (command) inside
						ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_REAR: begin
							if (count_q >= ple_pkg::CAP_CNT) begin
								st_d    = ple_pkg::ST_FULL;
								state_d = S_OUT;
							end else begin
								idx_d   = (command == ple_pkg::CMD_INS_FRONT) ? '0
								          : IW'(count_q);
								k_d     = IW'(count_q);
								state_d = S_UP_RD;
							end
						end
						ple_pkg::CMD_INS_POS: begin
							if (position == '0 || position > CW'(count_q + CW'(1))) begin
								st_d    = ple_pkg::ST_BADPOS;
								state_d = S_OUT;
							end else if (count_q >= ple_pkg::CAP_CNT) begin
								st_d    = ple_pkg::ST_FULL;
								state_d = S_OUT;
							end else begin
								idx_d   = IW'(pos_m1);
								k_d     = IW'(count_q);
								state_d = S_UP_RD;
							end
						end
						ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_REAR: begin
							if (count_q == '0) begin
								st_d    = ple_pkg::ST_EMPTY;
								state_d = S_OUT;
							end else begin
								k_d     = (command == ple_pkg::CMD_DEL_FRONT) ? '0
								          : IW'(count_q - CW'(1));
								state_d = S_TAKE_RD;
							end
						end
						ple_pkg::CMD_DEL_POS: begin
							if (count_q == '0) begin
								st_d    = ple_pkg::ST_EMPTY;
								state_d = S_OUT;
							end else if (position == '0 || position > count_q) begin
								st_d    = ple_pkg::ST_BADPOS;
								state_d = S_OUT;
							end else begin
								k_d     = IW'(pos_m1);
								state_d = S_TAKE_RD;
							end
						end
						default: begin
							if (count_q == '0) begin
								st_d    = ple_pkg::ST_EMPTY;
								state_d = S_OUT;
							end else begin
								k_d     = '0;
								state_d = S_SRCH_RD;
							end
						end
					endcase
				end
			end
			// open a hole: move entry k-1 up to k until k reaches the target
			S_UP_RD: begin
				if (k_q > idx_q) begin
					req.raddr = k_q - IW'(1);
					state_d   = S_UP_WR;
				end else begin
					req.we    = 1'b1;
					req.waddr = idx_q;
					req.wdata = item_q;
					count_d   = count_q + CW'(1);
					state_d   = S_OUT;
				end
			end
			S_UP_WR: begin
				req.we    = 1'b1;
				req.waddr = k_q;
				k_d       = k_q - IW'(1);
				state_d   = S_UP_RD;
			end
			S_TAKE_RD: begin
				req.raddr = k_q;
				state_d   = S_TAKE_CAP;
			end
			S_TAKE_CAP: begin
				rem_d   = rdata;
				state_d = S_DN_RD;
			end
			// close the gap: move entry k+1 down to k
			S_DN_RD: begin
				if (CW'(k_ext + CW'(1)) < count_q) begin
					req.raddr = k_q + IW'(1);
					state_d   = S_DN_WR;
				end else begin
					count_d = count_q - CW'(1);
					state_d = S_OUT;
				end
			end
			S_DN_WR: begin
				req.we    = 1'b1;
				req.waddr = k_q;
				k_d       = k_q + IW'(1);
				state_d   = S_DN_RD;
			end
			S_SRCH_RD: begin
				req.raddr = k_q;
				state_d   = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (rdata == item_q) begin
					found_d = CW'(k_ext + CW'(1));
					if (cmd_q == ple_pkg::CMD_DEL_VAL) begin
						rem_d   = item_q;
						state_d = S_DN_RD;
					end else begin
						state_d = S_OUT;
					end
				end else if (CW'(k_ext + CW'(1)) == count_q) begin
					st_d    = ple_pkg::ST_NOTFOUND;
					state_d = S_OUT;
				end else begin
					k_d     = k_q + IW'(1);
					state_d = S_SRCH_RD;
				end
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q     <= k_d;
		idx_q   <= idx_d;
		cmd_q   <= cmd_d;
		item_q  <= item_d;
		st_q    <= st_d;
		rem_q   <= rem_d;
		found_q <= found_d;
		if (out_load) begin
			out_st_q    <= st_q;
			out_rem_q   <= rem_q;
			out_found_q <= found_q;
			out_cnt_q   <= count_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_st_q;
	assign removed_value  = out_rem_q;
	assign found_position = out_found_q;
	assign entry_count    = out_cnt_q;

endmodule

// ===== hw/rtl/ple_store.sv =====
module ple_store (
	input  logic                             clk,
	input  ple_pkg::mem_req_t                req,
	output logic signed [ple_pkg::DATA_W-1:0] rdata
);

	logic signed [ple_pkg::DATA_W-1:0] mem [ple_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

// ===== sim/positional_list_engine_test.sv =====
module positional_list_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 1650;
	localparam int REPORT_MAX   = 10;

	typedef logic signed [ple_pkg::DATA_W-1:0] word_t;

	localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
	localparam word_t WORD_MIN = 32'sh8000_0000;

	typedef struct {
		logic [2:0] status;
		word_t      removed;
		logic [4:0] found;
		logic [4:0] count;
	} list_result_t;

	// Shadow copy of the list plus the results still owed by the block.
	class list_scoreboard;
		word_t        entries[$];
		list_result_t awaited[$];
		int           failures;

		function int pending();
			return awaited.size();
		endfunction

		function void note_command(input logic [2:0] cmd, input word_t value,
				input logic [4:0] pos);
			list_result_t r;
			int cnt;
			int p;
			r.status  = ple_pkg::ST_OK;
			r.removed = '0;
			r.found   = '0;
			cnt = entries.size();
			p   = int'(pos);
			case (cmd) inside
				ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_REAR: begin
					if (cnt >= ple_pkg::CAPACITY)
						r.status = ple_pkg::ST_FULL;
					else if (cmd == ple_pkg::CMD_INS_FRONT)
						entries.push_front(value);
					else
						entries.push_back(value);
				end
				ple_pkg::CMD_INS_POS: begin
					// position check wins over the full check
					if (p < 1 || p > cnt + 1)
						r.status = ple_pkg::ST_BADPOS;
					else if (cnt >= ple_pkg::CAPACITY)
						r.status = ple_pkg::ST_FULL;
					else
						entries.insert(p - 1, value);
				end
				ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_REAR: begin
					if (cnt == 0)
						r.status = ple_pkg::ST_EMPTY;
					else if (cmd == ple_pkg::CMD_DEL_FRONT)
						r.removed = entries.pop_front();
					else
						r.removed = entries.pop_back();
				end
				ple_pkg::CMD_DEL_POS: begin
					if (cnt == 0) begin
						r.status = ple_pkg::ST_EMPTY;
					end else if (p < 1 || p > cnt) begin
						r.status = ple_pkg::ST_BADPOS;
					end else begin
						r.removed = entries[p - 1];
						entries.delete(p - 1);
					end
				end
				default: begin
					if (cnt == 0) begin
						r.status = ple_pkg::ST_EMPTY;
					end else begin
						for (int k = cnt - 1; k >= 0; k--)
							if (entries[k] == value)
								r.found = 5'(k + 1);
						if (r.found == 0) begin
							r.status = ple_pkg::ST_NOTFOUND;
						end else if (cmd == ple_pkg::CMD_DEL_VAL) begin
							r.removed = entries[r.found - 1];
							entries.delete(r.found - 1);
						end
					end
				end
			endcase
			r.count = 5'(entries.size());
			awaited.push_back(r);
		endfunction

		function void check_result(input logic [2:0] st, input word_t rem,
				input logic [4:0] fnd, input logic [4:0] cnt);
			list_result_t e;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("unexpected result: status %0d removed %0d found %0d count %0d",
						st, rem, fnd, cnt);
				return;
			end
			e = awaited.pop_front();
			if (st !== e.status || rem !== e.removed || fnd !== e.found || cnt !== e.count) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display({"mismatch: status %0d/%0d removed %0d/%0d found %0d/%0d",
						" count %0d/%0d (exp/act)"},
						e.status, st, e.removed, rem, e.found, fnd, e.count, cnt);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] command;
	word_t      item;
	logic [4:0] position;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] status;
	word_t      removed_value;
	logic [4:0] found_position;
	logic [4:0] entry_count;

	list_scoreboard sb = new();
	int send_idle_pct = 7;
	int recv_idle_pct = 75;
	int fill_mode = 2;
	int cycles = 0;

	positional_list_engine DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.item           (item),
		.position       (position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.removed_value  (removed_value),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: take items when not stalled, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, removed_value, found_position, entry_count);
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	task automatic send_command(input logic [2:0] cmd, input word_t value,
			input logic [4:0] pos);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		item     <= value;
		position <= pos;
		do @(posedge clk); while (in_stall);
		sb.note_command(cmd, value, pos);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic send_random();
		logic [2:0] cmd;
		word_t      value;
		logic [4:0] pos;
		int cnt;
		int r;
		int ins_w;
		cnt = sb.entries.size();
		// drift between filling, draining and hovering so both full and empty recur
		if ($urandom_range(0, 49) == 0)
			fill_mode = $urandom_range(0, 2);
		if ($urandom_range(0, 19) == 0) begin
			cmd   = 3'($urandom_range(ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_SEARCH));
			value = $urandom;
			pos   = 5'($urandom_range(0, 31));
		end else begin
			case (fill_mode)
				0:       ins_w = 70;
				1:       ins_w = 15;
				default: ins_w = (cnt < ple_pkg::CAPACITY / 2) ? 55 : 35;
			endcase
			r = $urandom_range(0, 99);
			if (r < ins_w)
				cmd = 3'($urandom_range(ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_POS));
			else if (r < 80)
				cmd = 3'($urandom_range(ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_VAL));
			else
				cmd = ple_pkg::CMD_SEARCH;
			if ((cmd == ple_pkg::CMD_DEL_VAL || cmd == ple_pkg::CMD_SEARCH) && cnt > 0
					&& $urandom_range(0, 2) != 0)
				value = sb.entries[$urandom_range(0, cnt - 1)];
			else
				case ($urandom_range(0, 4)) inside
					0, 1:    value = $urandom_range(0, 7);
					2: begin
						case ($urandom_range(0, 3))
							0:       value = WORD_MAX;
							1:       value = WORD_MIN;
							2:       value = -1;
							default: value = 0;
						endcase
					end
					default: value = $urandom;
				endcase
			if ($urandom_range(0, 4) == 0)
				pos = 5'($urandom_range(0, 31));
			else
				pos = 5'($urandom_range(0, cnt + 2));
		end
		send_command(cmd, value, pos);
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		command   <= ple_pkg::CMD_INS_FRONT;
		item      <= '0;
		position  <= '0;
		out_stall <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list
		send_command(ple_pkg::CMD_SEARCH, 0, 5'd0);
		send_command(ple_pkg::CMD_DEL_FRONT, 0, 5'd0);
		send_command(ple_pkg::CMD_DEL_REAR, 0, 5'd0);
		send_command(ple_pkg::CMD_DEL_POS, 0, 5'd1);
		send_command(ple_pkg::CMD_DEL_VAL, 0, 5'd0);
		send_command(ple_pkg::CMD_INS_POS, 5, 5'd0);
		send_command(ple_pkg::CMD_INS_POS, 5, 5'd2);
		// extremes, then lookups and bad positions on a short list
		send_command(ple_pkg::CMD_INS_FRONT, WORD_MAX, 5'd0);
		send_command(ple_pkg::CMD_INS_REAR, WORD_MIN, 5'd0);
		send_command(ple_pkg::CMD_INS_POS, -1, 5'd2);
		send_command(ple_pkg::CMD_SEARCH, -1, 5'd0);
		send_command(ple_pkg::CMD_SEARCH, 12345, 5'd0);
		send_command(ple_pkg::CMD_DEL_VAL, 12345, 5'd0);
		send_command(ple_pkg::CMD_DEL_POS, 0, 5'd0);
		send_command(ple_pkg::CMD_DEL_POS, 0, 5'd4);
		send_command(ple_pkg::CMD_DEL_VAL, WORD_MAX, 5'd31);
		// fill up through the rear position, then hit the full cases
		for (int k = 0; k < ple_pkg::CAPACITY - 2; k++)
			send_command(ple_pkg::CMD_INS_POS, k, 5'(k + 3));
		send_command(ple_pkg::CMD_INS_FRONT, 7, 5'd0);
		send_command(ple_pkg::CMD_INS_POS, 7, 5'(ple_pkg::CAPACITY + 1));
		send_command(ple_pkg::CMD_INS_POS, 7, 5'(ple_pkg::CAPACITY + 2));
		send_command(ple_pkg::CMD_SEARCH, ple_pkg::CAPACITY - 3, 5'd0);
		send_command(ple_pkg::CMD_DEL_POS, 0, 5'(ple_pkg::CAPACITY));

		for (int i = 0; i < RANDOM_ITEMS / 3; i++)
			send_random();
		wait_drained();

		send_idle_pct = 75;
		recv_idle_pct = 7;
		for (int i = 0; i < RANDOM_ITEMS / 3; i++)
			send_random();
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); i++)
			send_random();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.failures == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
